/* design/spq_pkg.sv */
// shared constants, codes and cell control type for the sorted priority queue
package spq_pkg;

   localparam int DEPTH   = 16;
   localparam int PRI_W   = 8;
   localparam int VALUE_W = 32;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_BADPRI = 2'd3
   } status_type;

   typedef struct packed {
      logic               push;
      logic               pop;
      logic [VALUE_W-1:0] value;
      logic [PRI_W-1:0]   pri;
      logic [COUNT_W-1:0] count;
   } ctrl_type;

endpackage

/* design/spq_cell.sv */
// one slot of the sorted chain: compares against the new item and shifts
module spq_cell (
   input  logic                        clock,
   input  spq_pkg::ctrl_type           ctrl,
   input  logic [spq_pkg::IDX_W-1:0]   cell_index,
   input  logic [spq_pkg::VALUE_W-1:0] prev_value,
   input  logic [spq_pkg::PRI_W-1:0]   prev_pri,
   input  logic                        prev_place,
   input  logic [spq_pkg::VALUE_W-1:0] next_value,
   input  logic [spq_pkg::PRI_W-1:0]   next_pri,
   output logic [spq_pkg::VALUE_W-1:0] value,
   output logic [spq_pkg::PRI_W-1:0]   pri,
   output logic                        place
);
   import spq_pkg::*;

   logic [VALUE_W-1:0] value_ff, value_in;
   logic [PRI_W-1:0]   pri_ff, pri_in;
   logic               occupied;

   // slot is live when its index is below the fill count
   assign occupied = {1'b0, cell_index} < COUNT_W'(ctrl.count);
   // new item goes here or earlier
   assign place = !occupied || (pri_ff > ctrl.pri);

   always_comb begin
      value_in = value_ff;
      pri_in   = pri_ff;
      if (ctrl.push && place) begin
         if (prev_place) begin
            value_in = prev_value;
            pri_in   = prev_pri;
         end else begin
            value_in = ctrl.value;
            pri_in   = ctrl.pri;
         end
      end else if (ctrl.pop) begin
         value_in = next_value;
         pri_in   = next_pri;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      pri_ff   <= pri_in;
   end

   assign value = value_ff;
   assign pri   = pri_ff;

endmodule

/* design/sorted_priority_queue.sv */
// sorted priority queue top level: chain of compare-and-shift slots
// an accepted item's result is registered and raises rsp_tvalid in the next cycle
// throughput: one item per cycle, unless a held result is waiting on rsp_tready
// the result register frees up in the same cycle it is taken, so no bubbles
// reset: synchronous, clears fill count and result valid; slot contents are not cleared
module sorted_priority_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // value[31:0], priority_req[39:32]
   input  logic        req_tuser,  // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // popped_value[31:0], status[33:32], fill_count[38:34], zero
);
   import spq_pkg::*;

   logic                accept;
   logic                is_pop;
   logic [VALUE_W-1:0]  req_value;
   logic [PRI_W-1:0]    req_pri;
   logic                full;
   logic                empty;
   status_type          status;
   ctrl_type            ctrl;

   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]  rsp_fill_ff;

   logic [VALUE_W-1:0]  cell_value [DEPTH];
   logic [PRI_W-1:0]    cell_pri   [DEPTH];
   logic                cell_place [DEPTH];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_pop     = (op_type'(req_tuser) == OP_POP);
   assign req_value  = req_tdata[VALUE_W-1:0];
   assign req_pri    = req_tdata[VALUE_W +: PRI_W];
   assign full       = (count_ff == COUNT_W'(DEPTH));
   assign empty      = (count_ff == '0);

   always_comb begin
      if (is_pop) begin
         status = empty ? ST_EMPTY : ST_OK;
      end else if (req_pri == '0) begin
         status = ST_BADPRI;
      end else if (full) begin
         status = ST_FULL;
      end else begin
         status = ST_OK;
      end
   end

   always_comb begin
      ctrl.push  = accept && !is_pop && (status == ST_OK);
      ctrl.pop   = accept && is_pop && (status == ST_OK);
      ctrl.value = req_value;
      ctrl.pri   = req_pri;
      ctrl.count = count_ff;
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.push) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (ctrl.pop) begin
         count_in = count_ff - COUNT_W'(1);
      end
      rsp_valid_in  = accept ? 1'b1 : (rsp_valid_ff && !rsp_tready);
      rsp_value_in  = ctrl.pop ? cell_value[0] : '0;
      rsp_status_in = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
         rsp_fill_ff   <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_fill_ff, rsp_status_ff, rsp_value_ff};

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VALUE_W-1:0] prev_value;
      logic [PRI_W-1:0]   prev_pri;
      logic               prev_place;
      logic [VALUE_W-1:0] next_value;
      logic [PRI_W-1:0]   next_pri;

      if (i == 0) begin : g_head
         assign prev_value = req_value;
         assign prev_pri   = req_pri;
         assign prev_place = 1'b0;
      end else begin : g_body
         assign prev_value = cell_value[i-1];
         assign prev_pri   = cell_pri[i-1];
         assign prev_place = cell_place[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_value = cell_value[i];
         assign next_pri   = cell_pri[i];
      end else begin : g_link
         assign next_value = cell_value[i+1];
         assign next_pri   = cell_pri[i+1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .cell_index (IDX_W'(i)),
         .prev_value (prev_value),
         .prev_pri   (prev_pri),
         .prev_place (prev_place),
         .next_value (next_value),
         .next_pri   (next_pri),
         .value      (cell_value[i]),
         .pri        (cell_pri[i]),
         .place      (cell_place[i])
      );
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DEPTH))
      else $error("fill count above depth");

   a_pop_count : assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |=> count_ff == $past(count_ff) - COUNT_W'(1))
      else $error("pop did not lower fill count");

   a_push_count : assert property (@(posedge clock) disable iff (reset)
      ctrl.push |=> count_ff == $past(count_ff) + COUNT_W'(1))
      else $error("push did not raise fill count");

   a_fill_match : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_fill_ff == count_ff)
      else $error("reported fill count out of step");

endmodule
